// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define P2S_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define P2S_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define P2S_ASSERT(label, clk, rst_n, prop, msg)
`define P2S_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ----- rtl/p2s16_pkg.sv -----
// types and constants of the pcm to stereo16 converter
package p2s16_pkg;

    localparam int unsigned FRAME_CNT_W = 16;
    localparam int unsigned FRAME_LIMIT = 32768;

    localparam logic [1:0] MONO_CHANNELS = 2'd1;

    typedef enum logic {
        FMT_U8    = 1'b0,
        FMT_S16LE = 1'b1
    } t_sample_fmt;

    typedef enum logic [1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_SAMPLE_FORMAT = 2'd1,
        REG_SPARE_2       = 2'd2,
        REG_SPARE_3       = 2'd3
    } t_reg_index;

    // position of the next byte inside the source frame
    typedef enum logic [1:0] {
        PH_LEFT_LO  = 2'd0,
        PH_LEFT_HI  = 2'd1,
        PH_RIGHT_LO = 2'd2,
        PH_RIGHT_HI = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]  channel_count;
        t_sample_fmt sample_format;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               frame_valid;
        logic               frame_last;
    } t_out_item;

endpackage

// ----- rtl/p2s16_cfg_regs.sv -----
// configuration register file of the converter
module p2s16_cfg_regs
    import p2s16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_reg_index i_cfg_index,
    input  logic [1:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: n_cfg.channel_count = i_cfg_data;
                REG_SAMPLE_FORMAT: n_cfg.sample_format = t_sample_fmt'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= 2'd2;
            r_cfg.sample_format <= FMT_S16LE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/p2s16_frame_asm.sv -----
// frame assembly: byte phase, held bytes and frame limit
module p2s16_frame_asm
    import p2s16_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output logic      o_has_result,
    output t_out_item o_result
);

`include "assert_macros.svh"

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [7:0]             r_low_hold;
    logic [7:0]             n_low_hold;
    logic [15:0]            r_left_hold;
    logic [15:0]            n_left_hold;
    logic [FRAME_CNT_W-1:0] r_frames;
    logic [FRAME_CNT_W-1:0] n_frames;

    logic        mono;
    logic        done;
    logic        valid;
    logic [15:0] u8_word;
    logic [15:0] le_word;
    logic [15:0] left;
    logic [15:0] right;

    assign mono    = (i_cfg.channel_count == MONO_CHANNELS);
    assign u8_word = {i_item.data_byte ^ 8'h80, 8'h00};
    assign le_word = {i_item.data_byte, r_low_hold};

    always_comb begin
        n_phase     = r_phase;
        n_low_hold  = r_low_hold;
        n_left_hold = r_left_hold;
        n_frames    = r_frames;
        done        = 1'b0;
        valid       = 1'b0;
        left        = '0;
        right       = '0;

        if (i_cfg.sample_format == FMT_U8) begin
            if (mono) begin
                left  = u8_word;
                right = u8_word;
                done  = 1'b1;
            end else if (r_phase == PH_LEFT_LO) begin
                n_left_hold = u8_word;
                n_phase     = PH_LEFT_HI;
            end else begin
                left  = r_left_hold;
                right = u8_word;
                done  = 1'b1;
            end
        end else begin
            if (mono) begin
                if (r_phase == PH_LEFT_LO) begin
                    n_low_hold = i_item.data_byte;
                    n_phase    = PH_LEFT_HI;
                end else begin
                    left  = le_word;
                    right = le_word;
                    done  = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_LEFT_LO: begin
                        n_low_hold = i_item.data_byte;
                        n_phase    = PH_LEFT_HI;
                    end
                    PH_LEFT_HI: begin
                        n_left_hold = le_word;
                        n_phase     = PH_RIGHT_LO;
                    end
                    PH_RIGHT_LO: begin
                        n_low_hold = i_item.data_byte;
                        n_phase    = PH_RIGHT_HI;
                    end
                    PH_RIGHT_HI: begin
                        left  = r_left_hold;
                        right = le_word;
                        done  = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        if (done) begin
            n_phase = PH_LEFT_LO;
            if (r_frames < FRAME_CNT_W'(FRAME_LIMIT)) begin
                valid    = 1'b1;
                n_frames = r_frames + 1'b1;
            end
        end
        // frames past the limit give no result; a result without a valid frame reports zero samples
        if (!valid) begin
            left  = '0;
            right = '0;
        end
        if (i_item.last_byte) begin
            n_phase  = PH_LEFT_LO;
            n_frames = '0;
        end
    end

    assign o_has_result          = valid | i_item.last_byte;
    assign o_result.left_sample  = left;
    assign o_result.right_sample = right;
    assign o_result.frame_valid  = valid;
    assign o_result.frame_last   = i_item.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEFT_LO;
            r_low_hold  <= '0;
            r_left_hold <= '0;
            r_frames    <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_low_hold  <= n_low_hold;
            r_left_hold <= n_left_hold;
            r_frames    <= n_frames;
        end
    end

    `P2S_ASSERT(a_last_restarts, i_clk, i_rst_n, i_accept && i_item.last_byte |=> r_phase == PH_LEFT_LO && r_frames == '0, "last byte did not restart frame assembly")
    `P2S_ASSERT_NEVER(a_frames_bound, i_clk, i_rst_n, r_frames > FRAME_CNT_W'(FRAME_LIMIT), "frame count beyond limit")

endmodule

// ----- rtl/pcm_to_stereo16_converter_core.sv -----
// top level of the pcm byte stream to 16-bit stereo frame converter
// Takes one PCM byte per transfer and returns at most one stereo frame per byte, one byte
// every clock cycle at full rate. Each byte passes through the frame assembly logic in the
// cycle it is accepted and its result is registered in a single output register;
// the input stalls only while that register holds a result whose transfer is stalled.
// Configuration writes are always ready and take effect on the next byte; write them only
// while no byte is in flight.
module pcm_to_stereo16_converter_core
    import p2s16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_reg_index i_cfg_index,
    input  logic [1:0] i_cfg_data
);

`include "assert_macros.svh"

    t_cfg      cfg;
    logic      in_accept;
    logic      has_result;
    t_out_item result;

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_item;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    p2s16_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    p2s16_frame_asm u_frame_asm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // a finished transfer frees the register for the result of the current byte
    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        if (in_accept && has_result) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && has_result) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `P2S_ASSERT(a_zero_on_invalid, i_clk, i_rst_n, r_out_valid && !r_out_item.frame_valid |-> r_out_item.left_sample == '0 && r_out_item.right_sample == '0, "samples not cleared on invalid frame")
    `P2S_ASSERT(a_result_has_cause, i_clk, i_rst_n, r_out_valid |-> r_out_item.frame_valid || r_out_item.frame_last, "result without frame or last byte")

endmodule

// ----- dv/p2s16_frame_checker.sv -----
// frame checker: predicts stereo frames from byte transfers and compares output transfers
`timescale 1ns / 100ps
module p2s16_frame_checker
    import p2s16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  t_reg_index i_cfg_index,
    input  logic [1:0] i_cfg_data,
    output int         o_mismatches,
    output int         o_pending
);

    logic [1:0]             chan_cfg;
    t_sample_fmt            fmt_cfg;
    t_phase                 phase;
    logic [7:0]             low_hold;
    logic [15:0]            left_hold;
    logic [FRAME_CNT_W-1:0] stream_frames;
    t_out_item              pending_frames[$];
    int                     mismatch_count;

    // unsigned 8-bit sample to signed 16-bit: flip the sign bit, move to the top byte
    function automatic logic [15:0] widen_u8(logic [7:0] b);
        return {b ^ 8'h80, 8'h00};
    endfunction

    function void assemble_frame(t_in_item item);
        logic        mono;
        logic        done;
        logic        valid;
        logic [15:0] left;
        logic [15:0] right;
        t_out_item   frame;
        mono  = (chan_cfg == MONO_CHANNELS);
        done  = 1'b0;
        left  = '0;
        right = '0;
        if (fmt_cfg == FMT_U8) begin
            if (mono) begin
                left  = widen_u8(item.data_byte);
                right = left;
                done  = 1'b1;
            end else if (phase == PH_LEFT_LO) begin
                left_hold = widen_u8(item.data_byte);
                phase     = PH_LEFT_HI;
            end else begin
                left  = left_hold;
                right = widen_u8(item.data_byte);
                done  = 1'b1;
            end
        end else begin
            if (mono) begin
                if (phase == PH_LEFT_LO) begin
                    low_hold = item.data_byte;
                    phase    = PH_LEFT_HI;
                end else begin
                    left  = {item.data_byte, low_hold};
                    right = left;
                    done  = 1'b1;
                end
            end else if (phase == PH_LEFT_LO || phase == PH_RIGHT_LO) begin
                low_hold = item.data_byte;
                phase    = t_phase'(phase + 2'd1);
            end else if (phase == PH_LEFT_HI) begin
                left_hold = {item.data_byte, low_hold};
                phase     = PH_RIGHT_LO;
            end else begin
                left  = left_hold;
                right = {item.data_byte, low_hold};
                done  = 1'b1;
            end
        end

        valid = 1'b0;
        if (done) begin
            phase = PH_LEFT_LO;
            // frames past the per-stream limit are dropped
            if (stream_frames < FRAME_LIMIT) begin
                valid         = 1'b1;
                stream_frames = stream_frames + 1'b1;
            end
        end
        if (!valid) begin
            left  = '0;
            right = '0;
        end
        if (item.last_byte) begin
            phase         = PH_LEFT_LO;
            stream_frames = '0;
        end
        if (valid || item.last_byte) begin
            frame.left_sample  = left;
            frame.right_sample = right;
            frame.frame_valid  = valid;
            frame.frame_last   = item.last_byte;
            pending_frames.push_back(frame);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            chan_cfg       = 2'd2;
            fmt_cfg        = FMT_S16LE;
            phase          = PH_LEFT_LO;
            low_hold       = '0;
            left_hold      = '0;
            stream_frames  = '0;
            mismatch_count = 0;
            pending_frames.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_frames.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected frame: L=%0d R=%0d valid=%0b last=%0b",
                                 i_out_item.left_sample, i_out_item.right_sample,
                                 i_out_item.frame_valid, i_out_item.frame_last);
                    mismatch_count++;
                end else begin
                    want = pending_frames.pop_front();
                    if (i_out_item.left_sample  !== want.left_sample  ||
                        i_out_item.right_sample !== want.right_sample ||
                        i_out_item.frame_valid  !== want.frame_valid  ||
                        i_out_item.frame_last   !== want.frame_last) begin
                        if (mismatch_count < 10)
                            $display(
                                "mismatch: exp L=%0d R=%0d v=%0b l=%0b got L=%0d R=%0d v=%0b l=%0b",
                                want.left_sample, want.right_sample,
                                want.frame_valid, want.frame_last,
                                i_out_item.left_sample, i_out_item.right_sample,
                                i_out_item.frame_valid, i_out_item.frame_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CHANNEL_COUNT: chan_cfg = i_cfg_data;
                    REG_SAMPLE_FORMAT: fmt_cfg  = t_sample_fmt'(i_cfg_data[0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                assemble_frame(i_in_item);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_frames.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench top: drives pcm byte streams and register writes, reports the verdict
`timescale 1ns / 100ps
module tb_top;
    import p2s16_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_BYTES = 80;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_reg_index  i_cfg_index = REG_CHANNEL_COUNT;
    logic [1:0]  i_cfg_data  = '0;

    int          mismatches;
    int          pending;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          quiet_cycles = 0;
    logic [1:0]  cur_chan     = 2'd2;
    t_sample_fmt cur_fmt      = FMT_S16LE;

    pcm_to_stereo16_converter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    p2s16_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ends the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input t_in_item item);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // every expected frame delivered, then a settling wait for bytes that give no frame
    task automatic wait_idle();
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [1:0] value);
        i_in_valid <= 1'b0;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_CHANNEL_COUNT)
            cur_chan = value;
        else if (idx == REG_SAMPLE_FORMAT)
            cur_fmt = t_sample_fmt'(value[0]);
    endtask

    initial begin
        int len;
        int frame_len;
        int sent;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset layout is stereo 16-bit: full-scale frame, then a lone last byte
        send_byte({8'h00, 1'b0});
        send_byte({8'h80, 1'b0});
        send_byte({8'hFF, 1'b0});
        send_byte({8'h7F, 1'b0});
        send_byte({8'hA5, 1'b1});

        write_reg(REG_CHANNEL_COUNT, MONO_CHANNELS);
        write_reg(REG_SAMPLE_FORMAT, 2'(FMT_U8));
        send_byte({8'h00, 1'b0});
        send_byte({8'hFF, 1'b0});
        send_byte({8'h80, 1'b1});

        // stereo 8-bit, stream ends on a partial frame
        write_reg(REG_CHANNEL_COUNT, 2'd2);
        send_byte({8'h7F, 1'b0});
        send_byte({8'h81, 1'b0});
        send_byte({8'h55, 1'b1});

        write_reg(REG_CHANNEL_COUNT, MONO_CHANNELS);
        write_reg(REG_SAMPLE_FORMAT, 2'(FMT_S16LE));
        send_byte({8'h34, 1'b0});
        send_byte({8'h12, 1'b0});
        send_byte({8'hFF, 1'b0});
        send_byte({8'hFF, 1'b1});

        // layout switched with a frame half assembled
        write_reg(REG_CHANNEL_COUNT, 2'd2);
        send_byte({8'h01, 1'b0});
        send_byte({8'h02, 1'b0});
        write_reg(REG_SAMPLE_FORMAT, 2'(FMT_U8));
        send_byte({8'h03, 1'b0});
        send_byte({8'hC0, 1'b0});
        write_reg(REG_CHANNEL_COUNT, MONO_CHANNELS);
        send_byte({8'h40, 1'b0});

        // channel counts 3 and 0 behave as stereo
        write_reg(REG_SAMPLE_FORMAT, 2'(FMT_S16LE));
        write_reg(REG_CHANNEL_COUNT, 2'd3);
        send_byte({8'h11, 1'b0});
        send_byte({8'h22, 1'b0});
        send_byte({8'h33, 1'b0});
        send_byte({8'h44, 1'b1});
        write_reg(REG_CHANNEL_COUNT, 2'd0);
        send_byte({8'hAA, 1'b0});
        send_byte({8'hBB, 1'b0});
        send_byte({8'hCC, 1'b0});
        send_byte({8'hDD, 1'b0});
        send_byte({8'hEE, 1'b1});
        write_reg(REG_SPARE_2, 2'd3);
        write_reg(REG_SPARE_3, 2'd3);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_reg(REG_CHANNEL_COUNT, 2'($urandom_range(3)));
            write_reg(REG_SAMPLE_FORMAT, 2'($urandom_range(1)));
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 53; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 53; end
                default: begin idle_pct = 14; stall_pct <= 14; end
            endcase
            frame_len = ((cur_chan == MONO_CHANNELS) ? 1 : 2) *
                        ((cur_fmt == FMT_S16LE) ? 2 : 1);
            sent = 0;
            while (sent < SEGMENT_BYTES) begin
                // mostly whole-frame streams, some ragged ones
                if ($urandom_range(99) < 80)
                    len = frame_len * $urandom_range(1, 6);
                else
                    len = $urandom_range(1, 9);
                for (int k = 0; k < len; k++)
                    send_byte({8'($urandom_range(255)), k == len - 1});
                sent += len;
            end
        end

        i_in_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
